FILE: hw/rtl/pbs_pkg.sv
// Shared constants, types and tables of the paletted block store.
package pbs_pkg;

  localparam int CELL_W        = 12;
  localparam int CELLS         = 1 << CELL_W;
  localparam int WORD_BITS     = 32;
  localparam int MAX_BITS      = 12;
  localparam int BITS_W        = 4;
  localparam int PALETTE_DEPTH = 4096;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int COUNT_W       = PAL_AW + 1;
  localparam int MIN_CAPA      = WORD_BITS / MAX_BITS;
  localparam int WORDS         = (CELLS + MIN_CAPA - 1) / MIN_CAPA;
  localparam int WORD_AW       = $clog2(WORDS);
  localparam int SHIFT_W       = $clog2(WORD_BITS);
  localparam int CAPA_W        = SHIFT_W + 1;
  localparam int RECIP_SH      = 16;

  localparam logic [1:0] CMD_READ       = 2'd0;
  localparam logic [1:0] CMD_WRITE      = 2'd1;
  localparam logic [1:0] CMD_WRITE_DATA = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_APPENDED = 2'd1;
  localparam logic [1:0] ST_WIDENED  = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  typedef struct packed {
    logic [WORD_AW-1:0] word;
    logic [SHIFT_W-1:0] slot;
    logic [SHIFT_W-1:0] shift;
  } pbs_addr_t;

  // indices per 32-bit word
  function automatic logic [CAPA_W-1:0] capa(input logic [BITS_W-1:0] bits);
    logic [CAPA_W-1:0] c;
    case (bits)
      4'd1:               c = 6'd32;
      4'd2:               c = 6'd16;
      4'd3:               c = 6'd10;
      4'd4:               c = 6'd8;
      4'd5:               c = 6'd6;
      4'd6:               c = 6'd5;
      4'd7, 4'd8:         c = 6'd4;
      4'd9, 4'd10:        c = 6'd3;
      default:            c = 6'd2;
    endcase
    return c;
  endfunction

  // floor(2^16 / capa)
  function automatic logic [RECIP_SH-1:0] recip(input logic [BITS_W-1:0] bits);
    logic [RECIP_SH-1:0] r;
    case (bits)
      4'd1:               r = 16'd2048;
      4'd2:               r = 16'd4096;
      4'd3:               r = 16'd6553;
      4'd4:               r = 16'd8192;
      4'd5:               r = 16'd10922;
      4'd6:               r = 16'd13107;
      4'd7, 4'd8:         r = 16'd16384;
      4'd9, 4'd10:        r = 16'd21845;
      default:            r = 16'd32768;
    endcase
    return r;
  endfunction

  function automatic logic [PAL_AW-1:0] idx_mask(input logic [BITS_W-1:0] bits);
    logic [COUNT_W-1:0] m;
    m = (COUNT_W'(1) << bits) - COUNT_W'(1);
    return m[PAL_AW-1:0];
  endfunction

endpackage

FILE: hw/rtl/pbs_ram.sv
// Simple dual-port synchronous RAM, registered read.
module pbs_ram #(
  parameter int DW = 32,
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/pbs_addr.sv
// Cell number to packed word / slot / bit offset, three-stage pipeline.
module pbs_addr import pbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CELL_W-1:0] cell_no,
  input  logic [BITS_W-1:0] bits,
  output logic              done,
  output pbs_addr_t         res
);

  logic [CELL_W-1:0]              q_r, cel_r;
  logic [CAPA_W-1:0]              cap_r;
  logic [BITS_W-1:0]              b1_r, b2_r;
  logic [WORD_AW-1:0]             word_r, word_o_r;
  logic [SHIFT_W-1:0]             slot_r, slot_o_r, shift_r;
  logic [2:0]                     v_r;
  logic [CELL_W+RECIP_SH-1:0]     prod1;
  logic [CELL_W+CAPA_W-1:0]       prod2;
  logic [CELL_W+CAPA_W-1:0]       rem0;

  assign prod1 = (CELL_W+RECIP_SH)'(cell_no) * (CELL_W+RECIP_SH)'(recip(bits));
  assign prod2 = (CELL_W+CAPA_W)'(q_r) * (CELL_W+CAPA_W)'(cap_r);
  // quotient estimate is low by at most one
  assign rem0  = (CELL_W+CAPA_W)'(cel_r) - prod2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], start};
    end
    q_r   <= prod1[CELL_W+RECIP_SH-1:RECIP_SH];
    cel_r <= cell_no;
    cap_r <= capa(bits);
    b1_r  <= bits;
    if (rem0 >= (CELL_W+CAPA_W)'(cap_r)) begin
      word_r <= WORD_AW'(q_r + CELL_W'(1));
      slot_r <= SHIFT_W'(rem0 - (CELL_W+CAPA_W)'(cap_r));
    end else begin
      word_r <= WORD_AW'(q_r);
      slot_r <= SHIFT_W'(rem0);
    end
    b2_r     <= b1_r;
    word_o_r <= word_r;
    slot_o_r <= slot_r;
    shift_r  <= SHIFT_W'(slot_r * SHIFT_W'(b2_r));
  end

  assign done      = v_r[2];
  assign res.word  = word_o_r;
  assign res.slot  = slot_o_r;
  assign res.shift = shift_r;

endmodule

FILE: hw/rtl/paletted_block_store.sv
// Top level: paletted 16x16x16 cell store with packed index memory.
//
// Input stream: one command per transfer (read, write id+data, write data).
// Output stream: one result per command with the cell's record after the
// operation, a status code, and the current index width, palette count and
// modified flag.
// After reset the block runs a clearing pass over the 2048 words of the packed
// index memory, in_tready staying low; the palette starts as the single
// record zero with 1 bit per cell.
// A read passes the address pipeline, an index word read and a palette read
// before out_tvalid rises; in_tready rises with it for the next command.
// A write adds a palette search, one read and compare per entry present
// up to the first match, then a read-modify-write of the index word.
// When a new record meets a full palette the index width grows by one bit: the
// repack walks all 4096 cells downward, reading and repacking each in turn.
// One command is in work at a time; a finished result sits in the output
// register, so the next command is taken while the receiver stalls, and
// only its own result waits until that register is free.
module paletted_block_store import pbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[1:0], x_pos[5:2], y_pos[9:6], z_pos[13:10],
  // block_id[21:14], block_data[29:22], zero pad [31:30]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // id_out[7:0], data_out[15:8], status[17:16], bits_out[21:18],
  // count_out[34:22], modified_out[35], zero pad [39:36]
  output logic [39:0] out_tdata
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ADR, S_AWT, S_RDW, S_EXT, S_PRQ, S_PRD, S_SRD, S_SCMP,
    S_MISS, S_WA1, S_WW1, S_WA2, S_WW2, S_RPR, S_RPW, S_PUT, S_OUT
  } state_t;

  state_t               state_r;
  logic [1:0]           cmd_r;
  logic [CELL_W-1:0]    cell_r;
  logic [7:0]           in_id_r, in_dat_r;
  logic [BITS_W-1:0]    bits_r;
  logic [COUNT_W-1:0]   count_r;
  logic                 mod_r;
  logic [PAL_AW-1:0]    idx_r, srch_r;
  logic [31:0]          word_r, acc_r;
  logic [WORD_AW-1:0]   aw_r, ow_r, nw_r, clr_r;
  logic [SHIFT_W-1:0]   ash_r, oslot_r, oshift_r, nslot_r, nshift_r;
  logic [15:0]          old_rec_r, rec_r;
  logic [1:0]           status_r;
  logic                 put_r;
  logic [CELL_W-1:0]    cc_r;
  logic                 out_valid_r;
  logic [39:0]          out_data_r;

  logic                 a_start, a_done;
  logic [CELL_W-1:0]    a_cell;
  logic [BITS_W-1:0]    a_bits, nbits;
  pbs_addr_t            a_res;

  logic                 pk_we, pl_we;
  logic [WORD_AW-1:0]   pk_waddr, pk_raddr;
  logic [31:0]          pk_wdata, pk_rdata;
  logic [PAL_AW-1:0]    pl_waddr, pl_raddr;
  logic [15:0]          pl_wdata, pl_rdata;

  logic [PAL_AW-1:0]    fld, omask;
  logic [31:0]          acc_nxt;
  logic [15:0]          old_rec, new_rec;
  logic                 full, reject;
  logic [SHIFT_W-1:0]   otop_shift, ntop_shift;
  logic [CAPA_W-1:0]    ocap, ncap;

  assign nbits   = bits_r + BITS_W'(1);
  assign a_start = (state_r == S_ADR) || (state_r == S_WA1) || (state_r == S_WA2);
  assign a_cell  = (state_r == S_ADR) ? cell_r : CELL_W'(CELLS - 1);
  assign a_bits  = (state_r == S_WA2) ? nbits : bits_r;

  pbs_addr u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (a_start),
    .cell_no (a_cell),
    .bits    (a_bits),
    .done    (a_done),
    .res     (a_res)
  );

  pbs_ram #(.DW(32), .AW(WORD_AW)) u_cells (
    .clk   (clk),
    .we    (pk_we),
    .waddr (pk_waddr),
    .wdata (pk_wdata),
    .raddr (pk_raddr),
    .rdata (pk_rdata)
  );

  pbs_ram #(.DW(16), .AW(PAL_AW)) u_palette (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  assign omask      = idx_mask(bits_r);
  assign fld        = PAL_AW'(pk_rdata >> ((state_r == S_RPW) ? oshift_r : ash_r)) & omask;
  assign acc_nxt    = acc_r | (32'(fld) << nshift_r);
  assign ocap       = capa(bits_r);
  assign ncap       = capa(nbits);
  assign otop_shift = SHIFT_W'((ocap - CAPA_W'(1)) * CAPA_W'(bits_r));
  assign ntop_shift = SHIFT_W'((ncap - CAPA_W'(1)) * CAPA_W'(nbits));

  assign old_rec = ({1'b0, idx_r} < count_r) ? pl_rdata : 16'h0000;
  assign new_rec = (cmd_r == CMD_WRITE) ? {in_id_r, in_dat_r}
                                        : {old_rec[15:8], in_dat_r};
  assign full    = count_r >= (COUNT_W'(1) << bits_r);
  assign reject  = (count_r >= COUNT_W'(PALETTE_DEPTH)) ||
                   (full && (bits_r >= BITS_W'(MAX_BITS)));

  assign pk_raddr = (state_r == S_RPR) ? ow_r : aw_r;
  assign pl_raddr = (state_r == S_PRQ) ? idx_r : srch_r;

  always_comb begin
    pk_we    = 1'b0;
    pk_waddr = aw_r;
    pk_wdata = (word_r & ~(32'(omask) << ash_r)) | (32'(idx_r) << ash_r);
    pl_we    = 1'b0;
    pl_waddr = count_r[PAL_AW-1:0];
    pl_wdata = rec_r;
    case (state_r)
      S_CLR: begin
        pk_we    = 1'b1;
        pk_waddr = clr_r;
        pk_wdata = '0;
        pl_we    = (clr_r == '0);
        pl_waddr = '0;
        pl_wdata = '0;
      end
      S_PUT: pk_we = 1'b1;
      S_RPW: begin
        pk_we    = (nslot_r == '0) || (cc_r == '0);
        pk_waddr = nw_r;
        pk_wdata = acc_nxt;
      end
      S_MISS: pl_we = !reject;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      bits_r      <= BITS_W'(1);
      count_r     <= COUNT_W'(1);
      mod_r       <= 1'b0;
      out_valid_r <= 1'b0;
      put_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + WORD_AW'(1);
          if (clr_r == WORD_AW'(WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r    <= in_tdata[1:0];
            cell_r   <= {in_tdata[5:2], in_tdata[13:10], in_tdata[9:6]};
            in_id_r  <= in_tdata[21:14];
            in_dat_r <= in_tdata[29:22];
            put_r    <= 1'b0;
            status_r <= ST_OK;
            state_r  <= S_ADR;
          end
        end
        S_ADR: state_r <= S_AWT;
        S_AWT: begin
          if (a_done) begin
            aw_r    <= a_res.word;
            ash_r   <= a_res.shift;
            state_r <= S_RDW;
          end
        end
        S_RDW: state_r <= S_EXT;
        S_EXT: begin
          word_r <= pk_rdata;
          if (put_r) begin
            state_r <= S_PUT;
          end else begin
            idx_r   <= fld;
            state_r <= S_PRQ;
          end
        end
        S_PRQ: state_r <= S_PRD;
        S_PRD: begin
          old_rec_r <= old_rec;
          if (cmd_r == CMD_WRITE || cmd_r == CMD_WRITE_DATA) begin
            rec_r   <= new_rec;
            mod_r   <= 1'b1;
            srch_r  <= '0;
            state_r <= S_SRD;
          end else begin
            rec_r   <= old_rec;
            state_r <= S_OUT;
          end
        end
        S_SRD: state_r <= S_SCMP;
        S_SCMP: begin
          if (pl_rdata == rec_r) begin
            idx_r   <= srch_r;
            state_r <= S_PUT;
          end else if ((COUNT_W'(srch_r) + COUNT_W'(1)) >= count_r) begin
            state_r <= S_MISS;
          end else begin
            srch_r  <= srch_r + PAL_AW'(1);
            state_r <= S_SRD;
          end
        end
        S_MISS: begin
          if (reject) begin
            status_r <= ST_REJECTED;
            rec_r    <= old_rec_r;
            state_r  <= S_OUT;
          end else begin
            idx_r   <= count_r[PAL_AW-1:0];
            count_r <= count_r + COUNT_W'(1);
            if (full) begin
              status_r <= ST_WIDENED;
              state_r  <= S_WA1;
            end else begin
              status_r <= ST_APPENDED;
              state_r  <= S_PUT;
            end
          end
        end
        S_WA1: state_r <= S_WW1;
        S_WW1: begin
          if (a_done) begin
            ow_r     <= a_res.word;
            oslot_r  <= a_res.slot;
            oshift_r <= a_res.shift;
            state_r  <= S_WA2;
          end
        end
        S_WA2: state_r <= S_WW2;
        S_WW2: begin
          if (a_done) begin
            nw_r     <= a_res.word;
            nslot_r  <= a_res.slot;
            nshift_r <= a_res.shift;
            acc_r    <= '0;
            cc_r     <= CELL_W'(CELLS - 1);
            state_r  <= S_RPR;
          end
        end
        S_RPR: state_r <= S_RPW;
        // repack runs from the top cell down so each new word lands at or
        // above every old word still to be read
        S_RPW: begin
          if (nslot_r == '0) begin
            acc_r    <= '0;
            nw_r     <= nw_r - WORD_AW'(1);
            nslot_r  <= SHIFT_W'(ncap - CAPA_W'(1));
            nshift_r <= ntop_shift;
          end else begin
            acc_r    <= acc_nxt;
            nslot_r  <= nslot_r - SHIFT_W'(1);
            nshift_r <= nshift_r - SHIFT_W'(nbits);
          end
          if (oslot_r == '0) begin
            ow_r     <= ow_r - WORD_AW'(1);
            oslot_r  <= SHIFT_W'(ocap - CAPA_W'(1));
            oshift_r <= otop_shift;
          end else begin
            oslot_r  <= oslot_r - SHIFT_W'(1);
            oshift_r <= oshift_r - SHIFT_W'(bits_r);
          end
          if (cc_r == '0) begin
            bits_r  <= nbits;
            put_r   <= 1'b1;
            state_r <= S_ADR;
          end else begin
            cc_r    <= cc_r - CELL_W'(1);
            state_r <= S_RPR;
          end
        end
        S_PUT: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {4'b0000, mod_r, count_r, bits_r, status_r,
                            rec_r[7:0], rec_r[15:8]};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // count runs one above the index range while a widen is in work
  a_count_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> count_r <= (COUNT_W'(1) << bits_r))
    else $error("palette count exceeds index range");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r >= BITS_W'(1) && bits_r <= BITS_W'(MAX_BITS))
    else $error("index width out of range");

  a_widen_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RPW && cc_r == '0) |=> bits_r == $past(bits_r) + BITS_W'(1))
    else $error("repack did not widen index");
`endif

endmodule
